FILE: design/dmls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual motor lift sequencer package
// Shared types, command codes, request codes and register indexes.
// ----------------------------------------------------------------------------
package dmls_pkg;

  localparam logic [7:0] CMD_FINISH  = 8'h84;
  localparam logic [7:0] CMD_LOWER   = 8'h85;
  localparam logic [7:0] CMD_RAISE   = 8'h86;
  localparam logic [7:0] CMD_FINE    = 8'h87;
  localparam logic [7:0] CMD_PREMOVE = 8'hc4;
  localparam logic [7:0] CMD_IDLE    = 8'hfc;

  localparam logic [1:0] REQ_IDLE = 2'd0;
  localparam logic [1:0] REQ_UP   = 2'd1;
  localparam logic [1:0] REQ_DOWN = 2'd2;
  localparam logic [1:0] REQ_GOTO = 2'd3;

  localparam logic [1:0] STOP_LAST = 2'd3;

  localparam logic [1:0] REG_FINE_MARGIN      = 2'd0;
  localparam logic [1:0] REG_LOWEST_POSITION  = 2'd1;
  localparam logic [1:0] REG_HIGHEST_POSITION = 2'd2;

  localparam logic [9:0]  FINE_MARGIN_RESET      = 10'd110;
  localparam logic [15:0] LOWEST_POSITION_RESET  = 16'd177;
  localparam logic [15:0] HIGHEST_POSITION_RESET = 16'd6360;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_UP   = 3'd1,
    MODE_DOWN = 3'd2,
    MODE_GOTO = 3'd3,
    MODE_STOP = 3'd4
  } mode_t;

  typedef struct packed {
    logic [9:0]  fine_margin;
    logic [15:0] lowest_position;
    logic [15:0] highest_position;
  } cfg_t;

  typedef struct packed {
    logic [15:0] motor_a_position;
    logic [15:0] motor_b_position;
    logic        read_failed;
    logic [1:0]  move_request;
    logic [15:0] wanted_position;
  } in_item_t;

  typedef struct packed {
    logic [15:0] frame_position;
    logic [7:0]  frame_command;
    logic        clear_request;
    logic        positions_changed;
    logic [15:0] stored_a_position;
    logic [15:0] stored_b_position;
  } out_item_t;

endpackage

FILE: design/dmls_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one bus cycle's motor reports and request.
// ----------------------------------------------------------------------------
interface dmls_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] motor_a_position;
  logic [15:0] motor_b_position;
  logic        read_failed;
  logic [1:0]  move_request;
  logic [15:0] wanted_position;

  modport source (
    output valid, motor_a_position, motor_b_position, read_failed,
           move_request, wanted_position,
    input  ready
  );

  modport sink (
    input  valid, motor_a_position, motor_b_position, read_failed,
           move_request, wanted_position,
    output ready
  );
endinterface

FILE: design/dmls_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame channel
// Valid/ready channel carrying one command frame and the stored positions.
// ----------------------------------------------------------------------------
interface dmls_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_position;
  logic [7:0]  frame_command;
  logic        clear_request;
  logic        positions_changed;
  logic [15:0] stored_a_position;
  logic [15:0] stored_b_position;

  modport source (
    output valid, frame_position, frame_command, clear_request,
           positions_changed, stored_a_position, stored_b_position,
    input  ready
  );

  modport sink (
    input  valid, frame_position, frame_command, clear_request,
           positions_changed, stored_a_position, stored_b_position,
    output ready
  );
endinterface

FILE: design/dmls_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the fine margin and the two position limits, written by index.
// ----------------------------------------------------------------------------
module dmls_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output dmls_pkg::cfg_t cfg
);
  import dmls_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fine_margin      <= FINE_MARGIN_RESET;
      regs.lowest_position  <= LOWEST_POSITION_RESET;
      regs.highest_position <= HIGHEST_POSITION_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FINE_MARGIN:      regs.fine_margin      <= cfg_data[9:0];
        REG_LOWEST_POSITION:  regs.lowest_position  <= cfg_data;
        REG_HIGHEST_POSITION: regs.highest_position <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: design/dmls_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift sequencer
// Stores positions, applies limits and goto target, and builds one frame per
// word. State advances only when step is high.
// ----------------------------------------------------------------------------
module dmls_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  dmls_pkg::in_item_t  item,
  input  dmls_pkg::cfg_t      cfg,
  output dmls_pkg::out_item_t result
);
  import dmls_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] position_a;
  logic [15:0] position_b;
  logic [15:0] stop_target;
  logic [15:0] stop_target_next;
  logic [1:0]  stop_frames;
  logic [1:0]  stop_frames_next;
  logic        held_idle;
  logic        held_idle_next;

  logic        changed;
  logic [15:0] cur_a;
  logic [15:0] cur_b;
  logic        held_base;
  logic [1:0]  req;
  logic [15:0] lo;
  logic [15:0] hi;
  logic [16:0] max_diff;
  logic        lo_at_max;
  logic [16:0] min_sum;
  logic        hi_at_min;
  logic [16:0] up_t;
  logic [16:0] dn_t;
  logic        goto_up;
  logic        up_reached;
  logic        dn_reached;

  logic        stop_now;
  logic        force_idle;
  logic [15:0] stop_pos;
  mode_t       start_mode;

  assign changed   = !item.read_failed &&
                     (item.motor_a_position != position_a ||
                      item.motor_b_position != position_b);
  assign cur_a     = item.read_failed ? position_a : item.motor_a_position;
  assign cur_b     = item.read_failed ? position_b : item.motor_b_position;
  assign held_base = held_idle && (item.move_request != REQ_IDLE);
  assign req       = held_base ? REQ_IDLE : item.move_request;
  assign lo        = (cur_a < cur_b) ? cur_a : cur_b;
  assign hi        = (cur_a < cur_b) ? cur_b : cur_a;

  // A negative upper limit never triggers, as with wrapping 32-bit math.
  assign max_diff   = {1'b0, cfg.highest_position} - 17'(cfg.fine_margin);
  assign lo_at_max  = !max_diff[16] && (lo > max_diff[15:0]);
  assign min_sum    = {1'b0, cfg.lowest_position} + 17'(cfg.fine_margin);
  assign hi_at_min  = {1'b0, hi} < min_sum;
  assign up_t       = {1'b0, lo} + 17'(cfg.fine_margin);
  assign dn_t       = {1'b0, hi} - 17'(cfg.fine_margin);
  assign goto_up    = item.wanted_position > lo;
  assign up_reached = lo_at_max || (up_t >= {1'b0, item.wanted_position});
  assign dn_reached = hi_at_min ||
                      (!dn_t[16] && (dn_t[15:0] <= item.wanted_position));

  always_comb begin
    stop_now   = 1'b0;
    force_idle = 1'b0;
    stop_pos   = up_t[15:0];
    start_mode = MODE_IDLE;
    case (mode)
      MODE_UP: begin
        force_idle = lo_at_max;
        stop_now   = lo_at_max || (req != REQ_UP);
        stop_pos   = up_t[15:0];
      end
      MODE_DOWN: begin
        force_idle = hi_at_min;
        stop_now   = hi_at_min || (req != REQ_DOWN);
        stop_pos   = dn_t[15:0];
      end
      MODE_GOTO: begin
        stop_pos = goto_up ? up_t[15:0] : dn_t[15:0];
        if (req != REQ_GOTO) begin
          stop_now = 1'b1;
        end else begin
          force_idle = goto_up ? up_reached : dn_reached;
          stop_now   = force_idle;
        end
      end
      MODE_STOP: ;
      default: begin
        if (req == REQ_UP && !lo_at_max) begin
          start_mode = MODE_UP;
        end else if (req == REQ_DOWN && !hi_at_min) begin
          start_mode = MODE_DOWN;
        end else if (req == REQ_GOTO) begin
          start_mode = MODE_GOTO;
        end
      end
    endcase
  end

  always_comb begin
    mode_next        = mode;
    stop_target_next = stop_target;
    stop_frames_next = stop_frames;
    held_idle_next   = held_base || force_idle;
    case (mode)
      MODE_UP, MODE_DOWN, MODE_GOTO: begin
        if (stop_now) begin
          mode_next        = MODE_STOP;
          stop_target_next = stop_pos;
          stop_frames_next = 2'd0;
        end
      end
      MODE_STOP: begin
        if (stop_frames >= STOP_LAST) begin
          mode_next        = MODE_IDLE;
          stop_frames_next = 2'd0;
        end else begin
          stop_frames_next = stop_frames + 2'd1;
        end
      end
      default: mode_next = start_mode;
    endcase
  end

  always_comb begin
    result.clear_request     = force_idle;
    result.positions_changed = changed;
    result.stored_a_position = cur_a;
    result.stored_b_position = cur_b;
    result.frame_position    = lo;
    result.frame_command     = CMD_IDLE;
    case (mode)
      MODE_UP: begin
        result.frame_position = stop_now ? stop_pos : lo;
        result.frame_command  = stop_now ? CMD_FINE : CMD_RAISE;
      end
      MODE_DOWN: begin
        result.frame_position = stop_now ? stop_pos : hi;
        result.frame_command  = stop_now ? CMD_FINE : CMD_LOWER;
      end
      MODE_GOTO: begin
        if (stop_now) begin
          result.frame_position = stop_pos;
          result.frame_command  = CMD_FINE;
        end else begin
          result.frame_position = goto_up ? lo : hi;
          result.frame_command  = goto_up ? CMD_RAISE : CMD_LOWER;
        end
      end
      MODE_STOP: begin
        if (stop_frames >= STOP_LAST) begin
          result.frame_position = lo;
          result.frame_command  = CMD_FINISH;
        end else begin
          result.frame_position = stop_target;
          result.frame_command  = CMD_FINE;
        end
      end
      default: begin
        result.frame_command = (start_mode != MODE_IDLE) ? CMD_PREMOVE : CMD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      position_a  <= 16'd0;
      position_b  <= 16'd0;
      stop_target <= 16'd0;
      stop_frames <= 2'd0;
      held_idle   <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      position_a  <= cur_a;
      position_b  <= cur_b;
      stop_target <= stop_target_next;
      stop_frames <= stop_frames_next;
      held_idle   <= held_idle_next;
    end
  end

  a_frames_only_in_stop: assert property (@(posedge clk) disable iff (rst)
    (stop_frames != 2'd0) |-> (mode == MODE_STOP))
    else $error("stop frame count is nonzero outside the stopping state");

  a_stop_emits_fine_or_finish: assert property (@(posedge clk) disable iff (rst)
    (step && mode == MODE_STOP) |->
      (result.frame_command == CMD_FINE || result.frame_command == CMD_FINISH))
    else $error("stopping state sent a command other than fine or finish");

  a_clear_holds_request: assert property (@(posedge clk) disable iff (rst)
    (step && result.clear_request) |=> held_idle)
    else $error("forced idle did not hold the request");

  a_premove_from_idle: assert property (@(posedge clk) disable iff (rst)
    (step && result.frame_command == CMD_PREMOVE) |=>
      (mode == MODE_UP || mode == MODE_DOWN || mode == MODE_GOTO))
    else $error("premove frame did not start a move");

endmodule

FILE: design/dual_motor_lift_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual motor lift sequencer core
// Turns each bus cycle's motor reports and move request into one command
// frame, with limit handling and a fine stop sequence.
//
//   Channel   Kind        Direction  Contents
//   sample    valid/ready in         motor reports, read flag, request, target
//   frame     valid/ready out        frame position and command, flags, positions
//   cfg_*     write only  in         fine margin, lowest and highest position
//
// One word is accepted per cycle unless output stalls; it goes via in_q to out_q.
// The sequencer state updates when a word moves from the input register to
// the output register, so each word sees the state left by the previous one.
// A stalled frame output lets the input register fill once, then holds off input.
// Reset is synchronous and returns the sequencer and registers to defaults.
// ----------------------------------------------------------------------------
module dual_motor_lift_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  dmls_in_if.sink     sample,
  dmls_out_if.source  frame,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dmls_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid;
  out_item_t out_q;
  logic      out_valid;
  out_item_t result;
  logic      advance;

  assign advance      = in_valid && (!out_valid || frame.ready);
  assign sample.ready = !in_valid || advance;

  dmls_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmls_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_q.motor_a_position <= sample.motor_a_position;
      in_q.motor_b_position <= sample.motor_b_position;
      in_q.read_failed      <= sample.read_failed;
      in_q.move_request     <= sample.move_request;
      in_q.wanted_position  <= sample.wanted_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign frame.valid             = out_valid;
  assign frame.frame_position    = out_q.frame_position;
  assign frame.frame_command     = out_q.frame_command;
  assign frame.clear_request     = out_q.clear_request;
  assign frame.positions_changed = out_q.positions_changed;
  assign frame.stored_a_position = out_q.stored_a_position;
  assign frame.stored_b_position = out_q.stored_b_position;

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("word left the input register without reaching the output");

endmodule

FILE: tb/dmls_lift_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift sequencer frame checker
// Watches the sample and frame channels and the register write port. It keeps
// its own copy of the sequencer state and registers, works out the frame that
// each accepted sample word must produce, and compares every frame that the
// block hands over with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module dmls_lift_checker (
  input  logic        clk,
  input  logic        rst,
  dmls_in_if          sample,
  dmls_out_if         frame,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import dmls_pkg::*;

  logic [9:0]  margin;
  logic [15:0] low_limit;
  logic [15:0] high_limit;

  mode_t       mode;
  logic [15:0] pos_a;
  logic [15:0] pos_b;
  logic [15:0] stop_target;
  logic [2:0]  stop_count;
  logic        held_idle;

  out_item_t   frames_due[$];

  function automatic logic past_top(logic [31:0] p);
    logic [31:0] top_mark;
    top_mark = {16'd0, high_limit} - {22'd0, margin};
    return p > top_mark;
  endfunction

  function automatic logic below_floor(logic [31:0] p);
    return p < ({16'd0, low_limit} + {22'd0, margin});
  endfunction

  function automatic out_item_t next_frame(in_item_t w);
    out_item_t   f;
    logic [1:0]  req;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] want;
    logic [31:0] up_t;
    logic [31:0] dn_t;
    logic [31:0] stop_at;
    logic        going_up;
    logic        stopping;
    f = '0;
    f.frame_command = CMD_IDLE;
    stopping = 1'b0;
    stop_at = '0;
    if (!w.read_failed &&
        (w.motor_a_position != pos_a || w.motor_b_position != pos_b)) begin
      pos_a = w.motor_a_position;
      pos_b = w.motor_b_position;
      f.positions_changed = 1'b1;
    end
    if (w.move_request == REQ_IDLE) held_idle = 1'b0;
    req = held_idle ? REQ_IDLE : w.move_request;
    lo = (pos_a < pos_b) ? {16'd0, pos_a} : {16'd0, pos_b};
    hi = (pos_a < pos_b) ? {16'd0, pos_b} : {16'd0, pos_a};
    want = {16'd0, w.wanted_position};
    up_t = lo + {22'd0, margin};
    dn_t = hi - {22'd0, margin};
    going_up = want > lo;
    case (mode)
      MODE_UP: begin
        if (past_top(lo)) begin
          req = REQ_IDLE;
          held_idle = 1'b1;
          f.clear_request = 1'b1;
        end
        if (req != REQ_UP) begin
          stopping = 1'b1;
          stop_at = up_t;
        end else begin
          f.frame_position = lo[15:0];
          f.frame_command = CMD_RAISE;
        end
      end
      MODE_DOWN: begin
        if (below_floor(hi)) begin
          req = REQ_IDLE;
          held_idle = 1'b1;
          f.clear_request = 1'b1;
        end
        if (req != REQ_DOWN) begin
          stopping = 1'b1;
          stop_at = dn_t;
        end else begin
          f.frame_position = hi[15:0];
          f.frame_command = CMD_LOWER;
        end
      end
      MODE_GOTO: begin
        if (req != REQ_GOTO) begin
          stopping = 1'b1;
          stop_at = going_up ? up_t : dn_t;
        end else if (going_up) begin
          if (past_top(lo) || up_t >= want) begin
            held_idle = 1'b1;
            f.clear_request = 1'b1;
            stopping = 1'b1;
            stop_at = up_t;
          end else begin
            f.frame_position = lo[15:0];
            f.frame_command = CMD_RAISE;
          end
        end else begin
          if (below_floor(hi) || dn_t <= want) begin
            held_idle = 1'b1;
            f.clear_request = 1'b1;
            stopping = 1'b1;
            stop_at = dn_t;
          end else begin
            f.frame_position = hi[15:0];
            f.frame_command = CMD_LOWER;
          end
        end
      end
      MODE_STOP: begin
        if (stop_count >= STOP_LAST) begin
          stop_count = '0;
          mode = MODE_IDLE;
          f.frame_position = lo[15:0];
          f.frame_command = CMD_FINISH;
        end else begin
          stop_count = stop_count + 3'd1;
          f.frame_position = stop_target;
          f.frame_command = CMD_FINE;
        end
      end
      default: begin
        mode = MODE_IDLE;
        f.frame_position = lo[15:0];
        f.frame_command = CMD_IDLE;
        if (req == REQ_UP && !past_top(lo)) begin
          mode = MODE_UP;
          f.frame_command = CMD_PREMOVE;
        end else if (req == REQ_DOWN && !below_floor(hi)) begin
          mode = MODE_DOWN;
          f.frame_command = CMD_PREMOVE;
        end else if (req == REQ_GOTO) begin
          mode = MODE_GOTO;
          f.frame_command = CMD_PREMOVE;
        end
      end
    endcase
    if (stopping) begin
      mode = MODE_STOP;
      stop_target = stop_at[15:0];
      stop_count = '0;
      f.frame_position = stop_at[15:0];
      f.frame_command = CMD_FINE;
    end
    f.stored_a_position = pos_a;
    f.stored_b_position = pos_b;
    return f;
  endfunction

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t due;
    if (rst) begin
      margin = FINE_MARGIN_RESET;
      low_limit = LOWEST_POSITION_RESET;
      high_limit = HIGHEST_POSITION_RESET;
      mode = MODE_IDLE;
      pos_a = '0;
      pos_b = '0;
      stop_target = '0;
      stop_count = '0;
      held_idle = 1'b0;
      frames_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FINE_MARGIN:      margin = cfg_data[9:0];
          REG_LOWEST_POSITION:  low_limit = cfg_data;
          REG_HIGHEST_POSITION: high_limit = cfg_data;
          default: ;
        endcase
      end
      if (frame.valid && frame.ready) begin
        got.frame_position = frame.frame_position;
        got.frame_command = frame.frame_command;
        got.clear_request = frame.clear_request;
        got.positions_changed = frame.positions_changed;
        got.stored_a_position = frame.stored_a_position;
        got.stored_b_position = frame.stored_b_position;
        if (frames_due.size() == 0) begin
          $display("%0t: frame expected none got %p", $time, got);
          fail_count++;
        end else begin
          due = frames_due.pop_front();
          report_field("frame_position", due.frame_position, got.frame_position);
          report_field("frame_command", 16'(due.frame_command),
                       16'(got.frame_command));
          report_field("clear_request", 16'(due.clear_request),
                       16'(got.clear_request));
          report_field("positions_changed", 16'(due.positions_changed),
                       16'(got.positions_changed));
          report_field("stored_a_position", due.stored_a_position,
                       got.stored_a_position);
          report_field("stored_b_position", due.stored_b_position,
                       got.stored_b_position);
        end
      end
      if (sample.valid && sample.ready) begin
        frames_due.push_back(next_frame({sample.motor_a_position,
                                         sample.motor_b_position,
                                         sample.read_failed,
                                         sample.move_request,
                                         sample.wanted_position}));
      end
    end
    pending = frames_due.size();
  end

endmodule

FILE: tb/tb_dual_motor_lift_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual motor lift sequencer testbench
// Drives sample words into the core under several register settings: a
// directed pass through the limits, stops and goto cases, then random lift
// motion with noise, under changing backpressure. A separate checker predicts
// and compares every frame; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_motor_lift_sequencer_core;
  import dmls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 210;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        hold_asked;
  int          lift_pos;
  int          goto_aim;
  int          run_left;
  logic [1:0]  run_req;
  int          band_lo;
  int          band_hi;

  int set_margin[PHASES] = '{0, 1023, 110, 1023, 500, 0, 0, 0, 1023};
  int set_low[PHASES]    = '{0, 0, 177, 65535, 1000, 0, 65535, 0, 2000};
  int set_high[PHASES]   = '{65535, 65535, 6360, 0, 300, 0, 65535, 0, 60000};

  dmls_in_if  sample_ch ();
  dmls_out_if frame_ch ();

  dual_motor_lift_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .frame     (frame_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dmls_lift_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_ch),
    .frame      (frame_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [15:0] clip16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hffff;
    return 16'(v);
  endfunction

  function automatic in_item_t sample_word(logic [15:0] a, logic [15:0] b,
                                           logic failed, logic [1:0] req,
                                           logic [15:0] want);
    in_item_t w;
    w.motor_a_position = a;
    w.motor_b_position = b;
    w.read_failed = failed;
    w.move_request = req;
    w.wanted_position = want;
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.motor_a_position <= w.motor_a_position;
    sample_ch.motor_b_position <= w.motor_b_position;
    sample_ch.read_failed <= w.read_failed;
    sample_ch.move_request <= w.move_request;
    sample_ch.wanted_position <= w.wanted_position;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic hold_done;
    hold_done = 1'b0;
    frame_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked && !hold_done) begin
        hold_done = 1'b1;
        frame_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      frame_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    in_item_t w;
    int       step;
    int       ja;
    int       jb;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FINE_MARGIN;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.motor_a_position = '0;
    sample_ch.motor_b_position = '0;
    sample_ch.read_failed = 1'b0;
    sample_ch.move_request = REQ_IDLE;
    sample_ch.wanted_position = '0;
    hold_asked = 1'b0;
    tx_idle_pct = 17;
    rx_idle_pct = 59;
    run_left = 0;
    run_req = REQ_IDLE;
    goto_aim = 0;
    set_margin[5] = $urandom_range(1023);
    set_low[5] = $urandom_range(65535);
    set_high[5] = $urandom_range(65535);
    set_margin[7] = $urandom_range(300);
    set_low[7] = $urandom_range(3000);
    set_high[7] = $urandom_range(3000, 9000);
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: limits at 177 and 6360 with a margin of 110.
    send_word(sample_word(16'd0, 16'hffff, 1'b1, REQ_IDLE, 16'hffff));
    send_word(sample_word(16'hffff, 16'd0, 1'b0, REQ_IDLE, 16'd0));
    send_word(sample_word(16'd3000, 16'd3000, 1'b0, REQ_IDLE, 16'd0));
    send_word(sample_word(16'd3000, 16'd3000, 1'b0, REQ_UP, 16'd0));
    send_word(sample_word(16'd3040, 16'd3030, 1'b0, REQ_UP, 16'd0));
    send_word(sample_word(16'd3080, 16'd3070, 1'b0, REQ_IDLE, 16'd0));
    repeat (4) send_word(sample_word(16'd3090, 16'd3090, 1'b0, REQ_IDLE, 16'd0));
    send_word(sample_word(16'd6300, 16'd6290, 1'b0, REQ_UP, 16'd0));
    send_word(sample_word(16'd6300, 16'd6290, 1'b0, REQ_DOWN, 16'd0));
    send_word(sample_word(16'd3000, 16'd3000, 1'b0, REQ_DOWN, 16'd0));
    send_word(sample_word(16'd250, 16'd260, 1'b0, REQ_DOWN, 16'd0));
    send_word(sample_word(16'd250, 16'd260, 1'b0, REQ_DOWN, 16'd0));
    repeat (3) send_word(sample_word(16'd9, 16'd9, 1'b1, REQ_DOWN, 16'd0));
    send_word(sample_word(16'd250, 16'd260, 1'b0, REQ_DOWN, 16'd0));
    send_word(sample_word(16'd1000, 16'd1000, 1'b0, REQ_IDLE, 16'd0));
    send_word(sample_word(16'd1000, 16'd1000, 1'b0, REQ_GOTO, 16'd5000));
    send_word(sample_word(16'd2000, 16'd2000, 1'b0, REQ_GOTO, 16'd5000));
    send_word(sample_word(16'd4950, 16'd4960, 1'b0, REQ_GOTO, 16'd5000));
    repeat (4) send_word(sample_word(16'd4950, 16'd4960, 1'b0, REQ_IDLE, 16'd0));
    send_word(sample_word(16'd4950, 16'd4960, 1'b0, REQ_GOTO, 16'd100));
    send_word(sample_word(16'd1000, 16'd1000, 1'b0, REQ_GOTO, 16'd100));
    send_word(sample_word(16'd150, 16'd150, 1'b0, REQ_GOTO, 16'd100));
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 59;
        rx_idle_pct = 17;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      cfg_write <= 1'b1;
      cfg_index <= REG_FINE_MARGIN;
      cfg_data <= 16'(set_margin[ph]);
      @(negedge clk);
      cfg_index <= REG_LOWEST_POSITION;
      cfg_data <= 16'(set_low[ph]);
      @(negedge clk);
      cfg_index <= REG_HIGHEST_POSITION;
      cfg_data <= 16'(set_high[ph]);
      @(negedge clk);
      cfg_write <= 1'b0;

      band_lo = int'(clip16(((set_low[ph] < set_high[ph]) ? set_low[ph]
                                                           : set_high[ph]) - 400));
      band_hi = int'(clip16(((set_low[ph] < set_high[ph]) ? set_high[ph]
                                                           : set_low[ph]) + 400));
      lift_pos = $urandom_range(band_lo, band_hi);
      run_left = 0;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (ph == 1 && n == 40) hold_asked = 1'b1;
        if (ph == 4 && n == 100) settle();
        if (run_left == 0) begin
          run_left = $urandom_range(1, 14);
          run_req = 2'($urandom_range(3));
          goto_aim = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                               : $urandom_range(band_lo, band_hi);
        end
        run_left--;
        step = $urandom_range(80);
        if (run_req == REQ_UP) lift_pos = lift_pos + step;
        else if (run_req == REQ_DOWN) lift_pos = lift_pos - step;
        else if (run_req == REQ_GOTO)
          lift_pos = (lift_pos < goto_aim) ? lift_pos + step : lift_pos - step;
        lift_pos = int'(clip16(lift_pos));
        if ($urandom_range(99) < 12) begin
          w = sample_word(16'($urandom), 16'($urandom), 1'($urandom),
                          2'($urandom), 16'($urandom));
        end else begin
          ja = $urandom_range(20);
          jb = $urandom_range(20);
          w = sample_word(clip16(lift_pos + ja - 10), clip16(lift_pos + jb - 10),
                          $urandom_range(15) == 0, run_req, 16'(goto_aim));
        end
        send_word(w);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
